### rtl/wpjs_pkg.sv
// Shared types and constants of the weighted priority job scheduler.
`timescale 1ns / 1ps

package wpjs_pkg;

    // Default size of the job store.
    localparam int JOB_SLOTS_DEF = 64;

    // Field widths.
    localparam int TAG_W    = 16;
    localparam int UNITS_W  = 16;
    localparam int WEIGHT_W = 16;
    localparam int PROD_W   = WEIGHT_W + UNITS_W;
    localparam int PEN_W    = 40;
    localparam int ENTRY_W  = TAG_W + WEIGHT_W + UNITS_W;

    // Item command codes.
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic add_step;
        logic tick_step;
        logic add_commit;
        logic tick_commit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic add_done;
        logic tick_done;
    } t_dp_sts;

endpackage

### rtl/wpjs_dp.sv
// Datapath of the job scheduler: job store, slot scan, penalty and result registers.
`timescale 1ns / 1ps

module wpjs_dp #(
    parameter int JOB_SLOTS = wpjs_pkg::JOB_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wpjs_pkg::t_dp_cmd             i_cmd_bus,
    output wpjs_pkg::t_dp_sts             o_sts_bus,
    input  logic                          i_cmd,
    input  logic [wpjs_pkg::TAG_W-1:0]    i_job_tag,
    input  logic [wpjs_pkg::UNITS_W-1:0]  i_unit_count,
    input  logic [wpjs_pkg::WEIGHT_W-1:0] i_job_weight,
    output logic                          o_accepted,
    output logic                          o_served,
    output logic [wpjs_pkg::TAG_W-1:0]    o_served_tag,
    output logic [wpjs_pkg::WEIGHT_W-1:0] o_served_weight,
    output logic [wpjs_pkg::UNITS_W-1:0]  o_units_left,
    output logic                          o_job_finished,
    output logic [wpjs_pkg::PEN_W-1:0]    o_pending_penalty
);
    import wpjs_pkg::*;

    localparam int IDX_W = $clog2(JOB_SLOTS);
    localparam int CNT_W = $clog2(JOB_SLOTS + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(JOB_SLOTS);

    // Job store: one write port, one registered read port.
    logic [ENTRY_W-1:0] mem [JOB_SLOTS];
    logic [ENTRY_W-1:0] r_rd_data;

    // Per-slot valid bits and scan control.
    logic [JOB_SLOTS-1:0] r_valid;
    logic [CNT_W-1:0]     r_idx;
    logic                 r_found;
    logic                 r_pipe;
    logic                 r_pipe_vbit;
    logic [IDX_W-1:0]     r_pipe_idx;
    logic [IDX_W-1:0]     r_best_idx;
    logic [ENTRY_W-1:0]   r_best_data;
    logic [PEN_W-1:0]     r_pen;

    // Latched item and the weight times units product.
    logic                 r_in_cmd;
    logic [TAG_W-1:0]     r_in_tag;
    logic [UNITS_W-1:0]   r_in_units;
    logic [WEIGHT_W-1:0]  r_in_weight;
    logic [PROD_W-1:0]    r_prod;

    logic                 scan_end;
    logic [IDX_W-1:0]     scan_addr;
    logic                 add_ok;
    logic [WEIGHT_W-1:0]  rd_weight;
    logic [TAG_W-1:0]     best_tag;
    logic [WEIGHT_W-1:0]  best_weight;
    logic [UNITS_W-1:0]   best_units;
    logic [UNITS_W-1:0]   best_left;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_wa;
    logic [ENTRY_W-1:0]   mem_wd;

    // Field views and decisions.
    assign scan_end    = (r_idx == LAST_CNT);
    assign scan_addr   = r_idx[IDX_W-1:0];
    assign rd_weight   = r_rd_data[UNITS_W +: WEIGHT_W];
    assign best_tag    = r_best_data[UNITS_W+WEIGHT_W +: TAG_W];
    assign best_weight = r_best_data[UNITS_W +: WEIGHT_W];
    assign best_units  = r_best_data[UNITS_W-1:0];
    assign best_left   = best_units - UNITS_W'(1);
    assign add_ok      = r_found && (r_in_units != '0);

    assign o_sts_bus.add_done  = r_found || scan_end;
    assign o_sts_bus.tick_done = scan_end && !r_pipe;

    // Store write selection: a new job on add, the decremented count on tick.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_best_idx;
        mem_wd = {r_in_tag, r_in_weight, r_in_units};
        if (i_cmd_bus.add_commit && add_ok) begin
            mem_we = 1'b1;
        end else if (i_cmd_bus.tick_commit && r_found) begin
            mem_we = 1'b1;
            mem_wd = {best_tag, best_weight, best_left};
        end
    end

    // Job store write and scan read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (i_cmd_bus.tick_step && !scan_end) begin
            r_rd_data <= mem[scan_addr];
        end
    end

    // Latched item, product and scan payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.latch_in) begin
            r_in_cmd    <= i_cmd;
            r_in_tag    <= i_job_tag;
            r_in_units  <= i_unit_count;
            r_in_weight <= i_job_weight;
        end
        r_prod <= PROD_W'(r_in_weight) * PROD_W'(r_in_units);
        if (i_cmd_bus.tick_step && !scan_end) begin
            r_pipe_vbit <= r_valid[scan_addr];
            r_pipe_idx  <= scan_addr;
        end
        if (i_cmd_bus.tick_step && r_pipe && r_pipe_vbit
                && (!r_found || rd_weight > best_weight)) begin
            r_best_data <= r_rd_data;
        end
    end

    // Scan control, valid bits and penalty total.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_idx      <= '0;
            r_found    <= 1'b0;
            r_pipe     <= 1'b0;
            r_best_idx <= '0;
            r_pen      <= '0;
        end else begin
            if (i_cmd_bus.latch_in) begin
                r_idx   <= '0;
                r_found <= 1'b0;
                r_pipe  <= 1'b0;
            end
            // Free-slot search: stop at the lowest slot without a job.
            if (i_cmd_bus.add_step && !r_found && !scan_end) begin
                if (!r_valid[scan_addr]) begin
                    r_found    <= 1'b1;
                    r_best_idx <= scan_addr;
                end else begin
                    r_idx <= r_idx + CNT_W'(1);
                end
            end
            // Heaviest-job search: strict compare keeps the lowest slot on ties.
            if (i_cmd_bus.tick_step) begin
                r_pipe <= !scan_end;
                if (!scan_end) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
                if (r_pipe && r_pipe_vbit && (!r_found || rd_weight > best_weight)) begin
                    r_found    <= 1'b1;
                    r_best_idx <= r_pipe_idx;
                end
            end
            if (i_cmd_bus.add_commit && add_ok) begin
                r_valid[r_best_idx] <= 1'b1;
                r_pen <= r_pen + PEN_W'(r_prod);
            end
            if (i_cmd_bus.tick_commit && r_found) begin
                if (best_left == '0) begin
                    r_valid[r_best_idx] <= 1'b0;
                end
                r_pen <= r_pen - PEN_W'(best_weight);
            end
        end
    end

    // Result registers, loaded when an item completes.
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.add_commit) begin
            o_accepted        <= add_ok && (r_in_cmd == CMD_ADD);
            o_served          <= 1'b0;
            o_served_tag      <= '0;
            o_served_weight   <= '0;
            o_units_left      <= '0;
            o_job_finished    <= 1'b0;
            o_pending_penalty <= add_ok ? r_pen + PEN_W'(r_prod) : r_pen;
        end else if (i_cmd_bus.tick_commit) begin
            o_accepted        <= 1'b0;
            o_served          <= r_found;
            o_served_tag      <= r_found ? best_tag : '0;
            o_served_weight   <= r_found ? best_weight : '0;
            o_units_left      <= r_found ? best_left : '0;
            o_job_finished    <= r_found && (best_left == '0);
            o_pending_penalty <= r_found ? r_pen - PEN_W'(best_weight) : r_pen;
        end
    end

endmodule

### rtl/wpjs_ctrl.sv
// Controller of the job scheduler: item sequencing and result handshake.
`timescale 1ns / 1ps

module wpjs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_cmd,
    output logic              o_valid,
    input  logic              i_stall,
    output wpjs_pkg::t_dp_cmd o_cmd_bus,
    input  wpjs_pkg::t_dp_sts i_sts_bus
);
    import wpjs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_ADD_DONE,
        S_TICK,
        S_TICK_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   in_xfer;

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign in_xfer  = i_valid && !o_stall;
    // The result register can take a new result when empty or being emptied.
    assign out_free = !r_out_valid || !i_stall;

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_stall;
        o_cmd_bus   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    o_cmd_bus.latch_in = 1'b1;
                    n_state = (i_cmd == CMD_TICK) ? S_TICK : S_ADD;
                end
            end
            S_ADD: begin
                o_cmd_bus.add_step = 1'b1;
                if (i_sts_bus.add_done) begin
                    n_state = S_ADD_DONE;
                end
            end
            S_ADD_DONE: begin
                if (out_free) begin
                    o_cmd_bus.add_commit = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_TICK: begin
                o_cmd_bus.tick_step = 1'b1;
                if (i_sts_bus.tick_done) begin
                    n_state = S_TICK_DONE;
                end
            end
            S_TICK_DONE: begin
                if (out_free) begin
                    o_cmd_bus.tick_commit = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/weighted_priority_job_scheduler.sv
// An add completes once the free-slot search, which stops at the lowest empty slot, is
// done; a tick completes only after the scan has passed over every slot of the store.
// Items are taken one at a time; a tick holds the block for the slot scan through the
// single read port of the job store, and a result waits while the output holds the last.
// Reset: synchronous, active low; all slots become empty and the penalty total is zero,
// and the block is idle and ready to take an item as soon as reset is released.
`timescale 1ns / 1ps

module weighted_priority_job_scheduler #(
    parameter int JOB_SLOTS = wpjs_pkg::JOB_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_cmd,
    input  logic [wpjs_pkg::TAG_W-1:0]    i_job_tag,
    input  logic [wpjs_pkg::UNITS_W-1:0]  i_unit_count,
    input  logic [wpjs_pkg::WEIGHT_W-1:0] i_job_weight,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_accepted,
    output logic                          o_served,
    output logic [wpjs_pkg::TAG_W-1:0]    o_served_tag,
    output logic [wpjs_pkg::WEIGHT_W-1:0] o_served_weight,
    output logic [wpjs_pkg::UNITS_W-1:0]  o_units_left,
    output logic                          o_job_finished,
    output logic [wpjs_pkg::PEN_W-1:0]    o_pending_penalty
);
    import wpjs_pkg::*;

    t_dp_cmd cmd_bus;
    t_dp_sts sts_bus;

    // Sequencer.
    wpjs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_cmd     (i_cmd),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_cmd_bus (cmd_bus),
        .i_sts_bus (sts_bus)
    );

    // Job store and arithmetic.
    wpjs_dp #(
        .JOB_SLOTS (JOB_SLOTS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_bus         (cmd_bus),
        .o_sts_bus         (sts_bus),
        .i_cmd             (i_cmd),
        .i_job_tag         (i_job_tag),
        .i_unit_count      (i_unit_count),
        .i_job_weight      (i_job_weight),
        .o_accepted        (o_accepted),
        .o_served          (o_served),
        .o_served_tag      (o_served_tag),
        .o_served_weight   (o_served_weight),
        .o_units_left      (o_units_left),
        .o_job_finished    (o_job_finished),
        .o_pending_penalty (o_pending_penalty)
    );

`ifndef SYNTHESIS
    // A result is never both an accepted add and a served tick.
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_accepted && o_served))
        else $error("result flags both an add and a tick");

    // A finished job was served and has no units left.
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_job_finished) |-> (o_served && o_units_left == '0))
        else $error("finished job with units left or not served");

    // An input transfer always keeps the block busy in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block free right after an input transfer");

    // Every commit loads a valid result.
    a_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_bus.add_commit || cmd_bus.tick_commit) |=> o_valid)
        else $error("commit without a result");
`endif

endmodule
